/* src/sc3_pkg.sv */
// ----------------------------------------------------------------------------
// sc3_pkg: shared types and constants of the separable 3x3 convolution
// Holds the work queue entry, the coefficient bundle and register indexes.
// ----------------------------------------------------------------------------
package sc3_pkg;

    localparam int PIXEL_W    = 8;
    localparam int POS_W      = 10;
    localparam int COEF_W     = 16;
    localparam int VALUE_W    = 32;
    // A vertical sum of three 16x8 products fits in 26 signed bits.
    localparam int VSUM_W     = 26;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int M_TDATA_W  = 56;

    localparam logic [CFG_ADDR_W-1:0] CFG_VERT_ABOVE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VERT_CENTER  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VERT_BELOW   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HORIZ_LEFT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HORIZ_CENTER = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_HORIZ_RIGHT  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_ROW    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT    = 3'd7;

    // Window indexed [row][col]; row 0 is the oldest row, col 0 the leftmost.
    typedef logic [2:0][2:0][PIXEL_W-1:0] window_t;

    typedef struct packed {
        logic [2:0][COEF_W-1:0] vert;   // above, center, below
        logic [2:0][COEF_W-1:0] horiz;  // left, center, right
    } coef_t;

    typedef struct packed {
        window_t          win;
        logic [POS_W-1:0] row;        // row of the incoming pixel
        logic [POS_W-1:0] col;        // result column
        logic             emit_a;     // result for the row above
        logic             emit_b;     // bottom-row result
        logic             use_above;  // top tap present for the first result
    } job_t;

endpackage

/* src/sc3_ram.sv */
// ----------------------------------------------------------------------------
// sc3_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sc3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sc3_queue.sv */
// ----------------------------------------------------------------------------
// sc3_queue: short work queue between front and back
// A small register FIFO; the head entry is presented while not empty.
// ----------------------------------------------------------------------------
module sc3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/sc3_front.sv */
// ----------------------------------------------------------------------------
// sc3_front: pixel intake, line stores, window and result classification
// Tracks the raster position, updates the line RAM and the 3x3 window, and
// queues a job for every pixel that completes one or two results.
// ----------------------------------------------------------------------------
module sc3_front #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 160
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sc3_pkg::PIXEL_W-1:0]   s_tdata,
    input  logic                          s_tuser,
    input  logic [sc3_pkg::POS_W-1:0]     first_out_row,
    input  logic [sc3_pkg::COUNT_W-1:0]   out_row_count,
    output logic                          push_valid,
    input  logic                          push_ready,
    output sc3_pkg::job_t                 push_job
);

    localparam int ADDR_W = $clog2(FRAME_WIDTH);
    localparam logic [sc3_pkg::POS_W-1:0] LAST_COL = sc3_pkg::POS_W'(FRAME_WIDTH - 1);
    localparam logic [sc3_pkg::POS_W-1:0] LAST_ROW = sc3_pkg::POS_W'(FRAME_HEIGHT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PUSH
    } state_t;

    state_t                          state_reg;
    logic [sc3_pkg::POS_W-1:0]       col_reg, row_reg;
    logic [sc3_pkg::POS_W-1:0]       c_reg, r_reg;
    logic [sc3_pkg::PIXEL_W-1:0]     px_reg;
    sc3_pkg::window_t                win_reg, win_next;
    sc3_pkg::job_t                   job_reg;

    logic                            accept;
    logic [sc3_pkg::POS_W-1:0]       col_acc, row_acc;
    logic [2*sc3_pkg::PIXEL_W-1:0]   line_rd;
    logic [sc3_pkg::PIXEL_W-1:0]     two_up, one_up;
    logic [sc3_pkg::POS_W+1:0]       row_end;
    logic                            emit_a, emit_b;

    function automatic logic row_in_range(input logic [sc3_pkg::POS_W-1:0] r,
                                          input logic [sc3_pkg::POS_W-1:0] lo,
                                          input logic [sc3_pkg::POS_W+1:0] hi);
        row_in_range = (r >= lo) && ({2'b00, r} < hi);
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign col_acc  = s_tuser ? '0 : col_reg;
    assign row_acc  = s_tuser ? '0 : row_reg;

    // Line RAM word: upper byte is the row one up, lower byte the row two up.
    sc3_ram #(
        .WIDTH (2 * sc3_pkg::PIXEL_W),
        .DEPTH (FRAME_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (c_reg[ADDR_W-1:0]),
        .wr_data ({px_reg, one_up}),
        .rd_en   (accept),
        .rd_addr (col_acc[ADDR_W-1:0]),
        .rd_data (line_rd)
    );

    assign one_up = line_rd[2*sc3_pkg::PIXEL_W-1:sc3_pkg::PIXEL_W];
    assign two_up = line_rd[sc3_pkg::PIXEL_W-1:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = two_up;
        win_next[1][2] = one_up;
        win_next[2][2] = px_reg;
    end

    assign row_end = {2'b00, first_out_row} + {1'b0, out_row_count};
    assign emit_a  = (c_reg >= sc3_pkg::POS_W'(2)) && (r_reg != '0)
                     && row_in_range(r_reg - 1'b1, first_out_row, row_end);
    assign emit_b  = (c_reg >= sc3_pkg::POS_W'(2)) && (r_reg == LAST_ROW)
                     && row_in_range(r_reg, first_out_row, row_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            win_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        c_reg  <= col_acc;
                        r_reg  <= row_acc;
                        px_reg <= s_tdata;
                        if (col_acc == LAST_COL) begin
                            col_reg <= '0;
                            row_reg <= (row_acc == LAST_ROW) ? '0 : row_acc + 1'b1;
                        end else begin
                            col_reg <= col_acc + 1'b1;
                            row_reg <= row_acc;
                        end
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    win_reg           <= win_next;
                    job_reg.win       <= win_next;
                    job_reg.row       <= r_reg;
                    job_reg.col       <= c_reg - 1'b1;
                    job_reg.emit_a    <= emit_a;
                    job_reg.emit_b    <= emit_b;
                    job_reg.use_above <= (r_reg >= sc3_pkg::POS_W'(2));
                    state_reg         <= (emit_a || emit_b) ? ST_PUSH : ST_IDLE;
                end
                ST_PUSH: begin
                    if (push_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign push_valid = (state_reg == ST_PUSH);
    assign push_job   = job_reg;

endmodule

/* src/sc3_back.sv */
// ----------------------------------------------------------------------------
// sc3_back: multiply-accumulate sequencer and result register
// Works each queued job through one shared multiplier, twelve steps for each
// result: three vertical taps and one horizontal product per column.
// ----------------------------------------------------------------------------
module sc3_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sc3_pkg::coef_t                  coefs,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  sc3_pkg::job_t                   pop_job,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sc3_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    localparam logic [3:0] STEP_LAST = 4'd11;
    localparam logic [1:0] PHASE_H   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t                              state_reg;
    sc3_pkg::job_t                       job_reg;
    logic                                second_reg;
    logic [3:0]                          step_reg;
    logic signed [sc3_pkg::VSUM_W-1:0]   vacc_reg;
    logic [sc3_pkg::VALUE_W-1:0]         hacc_reg;

    logic                                m_valid_reg, out_last_reg;
    logic [sc3_pkg::POS_W-1:0]           out_row_reg, out_col_reg;
    logic [sc3_pkg::VALUE_W-1:0]         out_value_reg;

    logic [1:0]                          col_idx, phase, tap_row;
    logic                                tap_en;
    logic [sc3_pkg::PIXEL_W-1:0]         tap_pix;
    logic signed [sc3_pkg::COEF_W-1:0]   mul_coef;
    logic signed [sc3_pkg::VSUM_W-1:0]   mul_operand;
    logic signed [sc3_pkg::COEF_W+sc3_pkg::VSUM_W-1:0] prod;
    logic                                out_free;
    logic                                out_load;

    assign col_idx = step_reg[3:2];
    assign phase   = step_reg[1:0];
    // The bottom-row result uses the lower two window rows.
    assign tap_row = {1'b0, second_reg} + phase;
    assign tap_pix = job_reg.win[tap_row][col_idx];

    always_comb begin
        case (phase)
            2'd0:    tap_en = second_reg || job_reg.use_above;
            2'd1:    tap_en = 1'b1;
            2'd2:    tap_en = !second_reg;
            default: tap_en = 1'b0;
        endcase
    end

    always_comb begin
        case (phase)
            2'd0:    mul_coef = $signed(coefs.vert[2]);
            2'd1:    mul_coef = $signed(coefs.vert[1]);
            2'd2:    mul_coef = $signed(coefs.vert[0]);
            default: begin
                case (col_idx)
                    2'd0:    mul_coef = $signed(coefs.horiz[2]);
                    2'd1:    mul_coef = $signed(coefs.horiz[1]);
                    default: mul_coef = $signed(coefs.horiz[0]);
                endcase
            end
        endcase
    end

    assign mul_operand = (phase == PHASE_H) ? vacc_reg
                       : (tap_en ? $signed({{(sc3_pkg::VSUM_W-sc3_pkg::PIXEL_W){1'b0}}, tap_pix})
                                 : '0);
    assign prod        = mul_coef * mul_operand;
    assign out_free    = !m_valid_reg || m_tready;
    assign out_load    = (state_reg == ST_EMIT) && out_free;
    assign pop_ready   = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        job_reg    <= pop_job;
                        second_reg <= !pop_job.emit_a;
                        step_reg   <= '0;
                        hacc_reg   <= '0;
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (phase == PHASE_H) begin
                        hacc_reg <= hacc_reg + prod[sc3_pkg::VALUE_W-1:0];
                    end else if (phase == 2'd0) begin
                        vacc_reg <= prod[sc3_pkg::VSUM_W-1:0];
                    end else begin
                        vacc_reg <= vacc_reg + prod[sc3_pkg::VSUM_W-1:0];
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_row_reg   <= second_reg ? job_reg.row : job_reg.row - 1'b1;
                        out_col_reg   <= job_reg.col;
                        out_value_reg <= hacc_reg;
                        out_last_reg  <= second_reg || !job_reg.emit_b;
                        if (!second_reg && job_reg.emit_b) begin
                            second_reg <= 1'b1;
                            step_reg   <= '0;
                            hacc_reg   <= '0;
                            state_reg  <= ST_RUN;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(sc3_pkg::M_TDATA_W - sc3_pkg::VALUE_W - 2*sc3_pkg::POS_W){1'b0}},
                       out_value_reg, out_col_reg, out_row_reg};

endmodule

/* src/separable_conv_3x3_stream.sv */
// ----------------------------------------------------------------------------
// separable_conv_3x3_stream: streaming separable 3x3 convolution
// Filters raster-order 8-bit pixels with a vertical then horizontal kernel.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream, one transaction per pixel; s_tuser marks the
// first pixel of a frame. Results leave on the m_ stream with row, column and
// the 32-bit wrapped value; m_tlast flags the final result of a pixel. A
// pixel passes the front's idle and update states, and a push state when it
// yields results, and the front runs ahead of the back through a four-entry
// job queue. The back takes a job from the queue in its idle state, computes
// each result on one shared multiplier in its run state and loads it into the
// output register in its emit state. Coefficients and the row range are
// written on the cfg_ port while the block is idle; the user must keep to
// this, and the block itself does not enforce it. Reset empties the queue,
// drops any pending result, zeroes the window and position, and sets weights
// to zero and the row range to all rows; the line RAM needs no clearing.
// While m_tready is low the finished result is held, the back stops, and the
// front keeps taking pixels until the queue fills.
// ----------------------------------------------------------------------------
module separable_conv_3x3_stream #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 160
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,    // pixel
    input  logic [0:0]                        s_tuser,    // frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sc3_pkg::M_TDATA_W-1:0]     m_tdata,    // out_row, out_col, value
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [sc3_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sc3_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    sc3_pkg::coef_t                   coef_reg;
    logic [sc3_pkg::POS_W-1:0]        first_row_reg;
    logic [sc3_pkg::COUNT_W-1:0]      row_count_reg;

    logic                             push_valid, push_ready;
    logic                             pop_valid, pop_ready;
    sc3_pkg::job_t                    push_job, pop_job;
    logic [$bits(sc3_pkg::job_t)-1:0] pop_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg      <= '0;
            first_row_reg <= '0;
            row_count_reg <= sc3_pkg::COUNT_W'(1024);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sc3_pkg::CFG_VERT_ABOVE:   coef_reg.vert[2]  <= cfg_wr_data;
                sc3_pkg::CFG_VERT_CENTER:  coef_reg.vert[1]  <= cfg_wr_data;
                sc3_pkg::CFG_VERT_BELOW:   coef_reg.vert[0]  <= cfg_wr_data;
                sc3_pkg::CFG_HORIZ_LEFT:   coef_reg.horiz[2] <= cfg_wr_data;
                sc3_pkg::CFG_HORIZ_CENTER: coef_reg.horiz[1] <= cfg_wr_data;
                sc3_pkg::CFG_HORIZ_RIGHT:  coef_reg.horiz[0] <= cfg_wr_data;
                sc3_pkg::CFG_FIRST_ROW:    first_row_reg <= cfg_wr_data[sc3_pkg::POS_W-1:0];
                sc3_pkg::CFG_ROW_COUNT:    row_count_reg <= cfg_wr_data[sc3_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    sc3_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser[0]),
        .first_out_row (first_row_reg),
        .out_row_count (row_count_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    sc3_queue #(
        .WIDTH ($bits(sc3_pkg::job_t)),
        .DEPTH (sc3_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_bits)
    );

    assign pop_job = sc3_pkg::job_t'(pop_bits);

    sc3_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coefs     (coef_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
